[hdl/ax3r_pkg.sv]
// ---------------------------------------------------------------------------
// ax3r_pkg: shared types and constants of the 3D axis rotation unit
// Holds the default widths, the CORDIC gain and the arctangent table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ax3r_pkg;

    localparam int COORD_BITS_DEF  = 32;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int SINE_STAGES_DEF = 16;

    // Width of the CORDIC x/y datapath (Q2.30) and of the angle accumulator.
    localparam int CW = 32;
    localparam int ZW = 34;

    // CORDIC gain 0.60725293 in Q2.30.
    localparam logic signed [CW-1:0] GAIN_Q30 = 32'sd652032874;

    typedef enum logic [1:0] {
        AXIS_X    = 2'd0,
        AXIS_Y    = 2'd1,
        AXIS_Z    = 2'd2,
        AXIS_NONE = 2'd3
    } t_axis;

    // atan(2^-i) with a full turn scaled to 2^32.
    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0:       v = 34'sd536870912;
                1:       v = 34'sd316933406;
                2:       v = 34'sd167458907;
                3:       v = 34'sd85004756;
                4:       v = 34'sd42667331;
                5:       v = 34'sd21354465;
                6:       v = 34'sd10679838;
                7:       v = 34'sd5340245;
                8:       v = 34'sd2670163;
                9:       v = 34'sd1335087;
                10:      v = 34'sd667544;
                11:      v = 34'sd333772;
                12:      v = 34'sd166886;
                13:      v = 34'sd83443;
                14:      v = 34'sd41722;
                15:      v = 34'sd20861;
                16:      v = 34'sd10430;
                17:      v = 34'sd5215;
                18:      v = 34'sd2608;
                19:      v = 34'sd1304;
                20:      v = 34'sd652;
                21:      v = 34'sd326;
                22:      v = 34'sd163;
                23:      v = 34'sd81;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/ax3r_in_if.sv]
// ---------------------------------------------------------------------------
// ax3r_in_if: input channel of the 3D axis rotation unit
// Valid/ready channel carrying axis, angle and the input vector.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ax3r_in_if #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [ANGLE_BITS-1:0]        angle;
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic signed [COORD_BITS-1:0] z_in;

    modport source (output valid, action, angle, x_in, y_in, z_in, input ready);
    modport sink   (input valid, action, angle, x_in, y_in, z_in, output ready);
endinterface

`default_nettype wire

[hdl/ax3r_out_if.sv]
// ---------------------------------------------------------------------------
// ax3r_out_if: output channel of the 3D axis rotation unit
// Valid/ready channel carrying the rotated vector and the clip flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ax3r_out_if #(
    parameter int COORD_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] x_out;
    logic signed [COORD_BITS-1:0] y_out;
    logic signed [COORD_BITS-1:0] z_out;
    logic                         clipped;

    modport source (output valid, x_out, y_out, z_out, clipped, input ready);
    modport sink   (input valid, x_out, y_out, z_out, clipped, output ready);
endinterface

`default_nettype wire

[hdl/axis_rotate_3d_vector_unit.sv]
// ---------------------------------------------------------------------------
// axis_rotate_3d_vector_unit: rotates a 3D vector about one coordinate axis
// CORDIC sine/cosine front end, a short queue, and a multiply/round back end.
// ---------------------------------------------------------------------------
//  Channel  Dir  Payload                               Handshake
//  i_in     in   action, angle, x_in, y_in, z_in       valid / ready
//  o_out    out  x_out, y_out, z_out, clipped          valid / ready
//
//  One beat is taken every cycle while the front is not stalled; a beat
//  passes SINE_STAGES + 1 CORDIC stages, the queue entry, then product and
//  output stages.
//  The CORDIC pipeline, one stage per iteration, sets the depth of the front.
//  Reset is synchronous and active low; it clears all valid flags and the
//  queue pointers, and the datapath registers are left as they are.
//  The front stalls only when the queue is full, and the back only when the
//  output register holds a beat that has not been taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module axis_rotate_3d_vector_unit #(
    parameter int COORD_BITS  = ax3r_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS  = ax3r_pkg::ANGLE_BITS_DEF,
    parameter int SINE_STAGES = ax3r_pkg::SINE_STAGES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ax3r_in_if.sink    i_in,
    ax3r_out_if.source o_out
);
    import ax3r_pkg::*;

    // Queue entry: axis, cosine and sine (Q2.30 plus a sign guard), vector.
    localparam int JOB_W = 2 + 2 * (CW + 1) + 3 * COORD_BITS;

    logic             f_push;
    logic [JOB_W-1:0] f_job;
    logic [JOB_W-1:0] q_job;
    logic             q_full;
    logic             q_empty;
    logic             b_pop;

    // Front: takes beats and produces cosine and sine for each.
    ax3r_front #(
        .COORD_BITS  (COORD_BITS),
        .ANGLE_BITS  (ANGLE_BITS),
        .SINE_STAGES (SINE_STAGES),
        .JOB_W       (JOB_W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (f_push),
        .o_job   (f_job)
    );

    // Queue: lets the front keep going while the output is stalled.
    ax3r_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_pop   (b_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: rotation products, rounding, saturation and the output register.
    ax3r_back #(
        .COORD_BITS (COORD_BITS),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (q_job),
        .i_empty (q_empty),
        .o_pop   (b_pop),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    // The front never writes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(f_push && q_full))
        else $error("queue written while full");

    // The back never reads from an empty queue.
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(b_pop && q_empty))
        else $error("queue read while empty");

    // Reset leaves no result beat on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // A beat held on the output keeps the queue from being read.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !b_pop)
        else $error("queue read during output stall");
`endif

endmodule

`default_nettype wire

[hdl/ax3r_front.sv]
// ---------------------------------------------------------------------------
// ax3r_front: accepts beats and computes cosine and sine
// Pipelined CORDIC, one stage per iteration, then the quadrant mapping.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ax3r_front #(
    parameter int COORD_BITS  = ax3r_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS  = ax3r_pkg::ANGLE_BITS_DEF,
    parameter int SINE_STAGES = ax3r_pkg::SINE_STAGES_DEF,
    parameter int JOB_W       = 2 + 2 * (ax3r_pkg::CW + 1) + 3 * COORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    ax3r_in_if.sink               i_in,
    input  wire logic             i_full,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job
);
    import ax3r_pkg::*;

    localparam int N    = SINE_STAGES;
    localparam int VW   = 2 + 3 * COORD_BITS;
    localparam int ZSH  = 32 - ANGLE_BITS;

    logic signed [CW-1:0] r_x [0:N];
    logic signed [CW-1:0] r_y [0:N];
    logic signed [ZW-1:0] r_z [0:N];
    logic [1:0]           r_q [0:N];
    logic [VW-1:0]        r_vec [0:N];
    logic                 r_v [0:N];

    logic en;
    logic signed [CW:0] c_val;
    logic signed [CW:0] s_val;
    logic signed [CW:0] x_ext;
    logic signed [CW:0] y_ext;

    assign en         = !r_v[N] || !i_full;
    assign i_in.ready = en;
    assign o_push     = r_v[N] && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_in.valid;
        end
        if (en) begin
            r_x[0]   <= GAIN_Q30;
            r_y[0]   <= '0;
            r_z[0]   <= ZW'(i_in.angle[ANGLE_BITS-3:0]) <<< ZSH;
            r_q[0]   <= i_in.angle[ANGLE_BITS-1:ANGLE_BITS-2];
            r_vec[0] <= {i_in.action, i_in.x_in, i_in.y_in, i_in.z_in};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [ZW-1:0] T = atan_turn(k);
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (en) begin
                r_v[k+1] <= r_v[k];
            end
            if (en) begin
                if (!r_z[k][ZW-1]) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - T;
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + T;
                end
                r_q[k+1]   <= r_q[k];
                r_vec[k+1] <= r_vec[k];
            end
        end
    end

    // Fold the first-quadrant result into the quadrant of the angle.
    always_comb begin
        x_ext = {r_x[N][CW-1], r_x[N]};
        y_ext = {r_y[N][CW-1], r_y[N]};
        case (r_q[N])
            2'd0:    begin c_val = x_ext;  s_val = y_ext;  end
            2'd1:    begin c_val = -y_ext; s_val = x_ext;  end
            2'd2:    begin c_val = -x_ext; s_val = -y_ext; end
            default: begin c_val = y_ext;  s_val = -x_ext; end
        endcase
    end

    assign o_job = {r_vec[N][VW-1:VW-2], c_val, s_val, r_vec[N][VW-3:0]};

endmodule

`default_nettype wire

[hdl/ax3r_queue.sv]
// ---------------------------------------------------------------------------
// ax3r_queue: short queue between front and back
// Four-entry register FIFO with a fill count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ax3r_queue #(
    parameter int JOB_W = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [JOB_W-1:0] i_job,
    input  wire logic             i_pop,
    output logic [JOB_W-1:0]      o_job,
    output logic                  o_full,
    output logic                  o_empty
);
    localparam int DEPTH = 4;

    logic [JOB_W-1:0] r_mem [0:DEPTH-1];
    logic [1:0]       r_wr;
    logic [1:0]       r_rd;
    logic [2:0]       r_cnt;
    logic [2:0]       n_cnt;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_job   = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 3'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 2'd1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

`default_nettype wire

[hdl/ax3r_back.sv]
// ---------------------------------------------------------------------------
// ax3r_back: rotation products, rounding and saturation
// Registered products, then sum, round, clip and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ax3r_back #(
    parameter int COORD_BITS = ax3r_pkg::COORD_BITS_DEF,
    parameter int JOB_W      = 2 + 2 * (ax3r_pkg::CW + 1) + 3 * COORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [JOB_W-1:0] i_job,
    input  wire logic             i_empty,
    output logic                  o_pop,
    ax3r_out_if.source            o_out
);
    import ax3r_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int FW = CW + 1;
    localparam int PW = C + FW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] MAXV = {{(SW-C+1){1'b0}}, {(C-1){1'b1}}};
    localparam logic signed [SW-1:0] MINV = {{(SW-C+1){1'b1}}, {(C-1){1'b0}}};
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< 29;

    t_axis               j_axis;
    logic signed [FW-1:0] j_c, j_s, j_ns;
    logic signed [C-1:0]  j_x, j_y, j_z;
    logic signed [FW-1:0] fa1, fa2, fb1, fb2;
    logic signed [C-1:0]  va1, va2, vb1, vb2;

    logic                 en;
    logic                 r_b1v;
    t_axis                r_axis;
    logic signed [C-1:0]  r_x, r_y, r_z;
    logic signed [PW-1:0] r_pa1, r_pa2, r_pb1, r_pb2;

    logic signed [SW-1:0] ra, rb;
    logic signed [C-1:0]  sa, sb;
    logic                 ca, cb;

    assign j_axis = t_axis'(i_job[JOB_W-1:JOB_W-2]);
    assign j_c    = i_job[JOB_W-3 -: FW];
    assign j_s    = i_job[JOB_W-3-FW -: FW];
    assign j_x    = i_job[3*C-1 -: C];
    assign j_y    = i_job[2*C-1 -: C];
    assign j_z    = i_job[C-1:0];
    assign j_ns   = -j_s;

    assign en    = !o_out.valid || o_out.ready;
    assign o_pop = !i_empty && en;

    // Pick the two factor/coordinate pairs of each rotated coordinate.
    always_comb begin
        case (j_axis)
            AXIS_X: begin
                fa1 = j_c; va1 = j_y; fa2 = j_s;  va2 = j_z;
                fb1 = j_c; vb1 = j_z; fb2 = j_ns; vb2 = j_y;
            end
            AXIS_Y: begin
                fa1 = j_c; va1 = j_x; fa2 = j_s;  va2 = j_z;
                fb1 = j_c; vb1 = j_z; fb2 = j_ns; vb2 = j_x;
            end
            AXIS_Z: begin
                fa1 = j_c; va1 = j_x; fa2 = j_ns; va2 = j_y;
                fb1 = j_s; vb1 = j_x; fb2 = j_c;  vb2 = j_y;
            end
            default: begin
                fa1 = '0; va1 = '0; fa2 = '0; va2 = '0;
                fb1 = '0; vb1 = '0; fb2 = '0; vb2 = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1v       <= 1'b0;
            o_out.valid <= 1'b0;
        end else if (en) begin
            r_b1v       <= o_pop;
            o_out.valid <= r_b1v;
        end
        if (en) begin
            r_axis <= j_axis;
            r_x    <= j_x;
            r_y    <= j_y;
            r_z    <= j_z;
            r_pa1  <= PW'(fa1 * va1);
            r_pa2  <= PW'(fa2 * va2);
            r_pb1  <= PW'(fb1 * vb1);
            r_pb2  <= PW'(fb2 * vb2);
        end
    end

    // Round to nearest (ties up), drop the 30 fraction bits, then clip.
    always_comb begin
        ra = (SW'(r_pa1) + SW'(r_pa2) + HALF) >>> 30;
        rb = (SW'(r_pb1) + SW'(r_pb2) + HALF) >>> 30;
        ca = (ra > MAXV) || (ra < MINV);
        cb = (rb > MAXV) || (rb < MINV);
        sa = (ra > MAXV) ? MAXV[C-1:0] : ((ra < MINV) ? MINV[C-1:0] : ra[C-1:0]);
        sb = (rb > MAXV) ? MAXV[C-1:0] : ((rb < MINV) ? MINV[C-1:0] : rb[C-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            case (r_axis)
                AXIS_X: begin
                    o_out.x_out <= r_x; o_out.y_out <= sa; o_out.z_out <= sb;
                    o_out.clipped <= ca || cb;
                end
                AXIS_Y: begin
                    o_out.x_out <= sa; o_out.y_out <= r_y; o_out.z_out <= sb;
                    o_out.clipped <= ca || cb;
                end
                AXIS_Z: begin
                    o_out.x_out <= sa; o_out.y_out <= sb; o_out.z_out <= r_z;
                    o_out.clipped <= ca || cb;
                end
                default: begin
                    o_out.x_out <= r_x; o_out.y_out <= r_y; o_out.z_out <= r_z;
                    o_out.clipped <= 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[tb/axis_rotate_3d_vector_unit_checker.sv]
// ---------------------------------------------------------------------------
// axis_rotate_3d_vector_unit_checker: scoreboard of the 3D axis rotation unit
// Watches both channels, predicts each rotated vector and compares in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_rotate_3d_vector_unit_checker
    import ax3r_pkg::*;
#(
    parameter int COORD_BITS  = 32,
    parameter int ANGLE_BITS  = 16,
    parameter int SINE_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ax3r_in_if         in_ch,
    ax3r_out_if        out_ch,
    output int         o_errors,
    output int         o_pending,
    output int         o_results
);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic                         clip;
    } t_rotated;

    t_rotated rotated_q[$];

    initial begin
        o_errors  = 0;
        o_results = 0;
    end
    assign o_pending = rotated_q.size();

    // Floor division by a power of two; >>> on a signed longint does that.
    function automatic longint asr(input longint v, input int sh);
        return v >>> sh;
    endfunction

    // CORDIC sine and cosine of a binary angle, as Q2.30.
    function automatic void sine_cosine(input logic [ANGLE_BITS-1:0] ang,
                                        output longint c, output longint s);
        logic [1:0] quad;
        longint     xa, ya, za, dx, dy;
        quad = ang[ANGLE_BITS-1 -: 2];
        za   = longint'(ang[ANGLE_BITS-3:0]) <<< (32 - ANGLE_BITS);
        xa   = GAIN_Q30;
        ya   = 0;
        for (int i = 0; i < SINE_STAGES && i < 24; i++) begin
            dx = asr(ya, i);
            dy = asr(xa, i);
            if (za >= 0) begin
                xa -= dx; ya += dy; za -= longint'(atan_turn(i));
            end else begin
                xa += dx; ya -= dy; za += longint'(atan_turn(i));
            end
        end
        case (quad)
            2'd0: begin c = xa;  s = ya;  end
            2'd1: begin c = -ya; s = xa;  end
            2'd2: begin c = -xa; s = -ya; end
            default: begin c = ya; s = -xa; end
        endcase
    endfunction

    // Two Q2.30 products summed exactly, rounded half up, saturated. The
    // coordinate is split so no partial sum overflows 64 bits.
    function automatic longint mac_round(input longint f1, input longint v1,
                                         input longint f2, input longint v2,
                                         inout logic clip);
        longint h1, l1, h2, l2, hi, lo, res, maxv, minv;
        h1 = asr(v1, 24); l1 = v1 - h1 * 64'sd16777216;
        h2 = asr(v2, 24); l2 = v2 - h2 * 64'sd16777216;
        hi = f1 * h1 + f2 * h2;
        lo = f1 * l1 + f2 * l2 + (64'sd1 <<< 29);
        res  = asr(hi + asr(lo, 24), 6);
        maxv = (64'sd1 <<< (COORD_BITS - 1)) - 1;
        minv = -maxv - 1;
        if (res > maxv) begin
            clip = 1'b1;
            return maxv;
        end
        if (res < minv) begin
            clip = 1'b1;
            return minv;
        end
        return res;
    endfunction

    function automatic t_rotated rotate_vector(input logic [1:0] axis,
                                               input logic [ANGLE_BITS-1:0] ang,
                                               input longint xv, input longint yv,
                                               input longint zv);
        longint   c, s, xo, yo, zo;
        logic     clip;
        t_rotated r;
        clip = 1'b0;
        xo = xv; yo = yv; zo = zv;
        sine_cosine(ang, c, s);
        case (t_axis'(axis))
            AXIS_X: begin
                yo = mac_round(c, yv, s, zv, clip);
                zo = mac_round(c, zv, -s, yv, clip);
            end
            AXIS_Y: begin
                xo = mac_round(c, xv, s, zv, clip);
                zo = mac_round(c, zv, -s, xv, clip);
            end
            AXIS_Z: begin
                xo = mac_round(c, xv, -s, yv, clip);
                yo = mac_round(s, xv, c, yv, clip);
            end
            default: ;
        endcase
        r.x = xo[COORD_BITS-1:0];
        r.y = yo[COORD_BITS-1:0];
        r.z = zo[COORD_BITS-1:0];
        r.clip = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_rotated want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                rotated_q = {rotated_q, rotate_vector(in_ch.action, in_ch.angle,
                    longint'(in_ch.x_in), longint'(in_ch.y_in), longint'(in_ch.z_in))};
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (rotated_q.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = rotated_q.pop_front();
                    if (out_ch.x_out !== want.x)
                        report_mismatch("x_out", out_ch.x_out, want.x);
                    if (out_ch.y_out !== want.y)
                        report_mismatch("y_out", out_ch.y_out, want.y);
                    if (out_ch.z_out !== want.z)
                        report_mismatch("z_out", out_ch.z_out, want.z);
                    if (out_ch.clipped !== want.clip)
                        report_mismatch("clipped", out_ch.clipped, want.clip);
                end
            end
        end
    end

endmodule

[tb/axis_rotate_3d_vector_unit_test.sv]
// ---------------------------------------------------------------------------
// axis_rotate_3d_vector_unit_test: top of the 3D axis rotation testbench
// Drives directed and random rotation beats with random gaps and stalls,
// including a long output stall, and reports the checker's verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module axis_rotate_3d_vector_unit_test;
    import ax3r_pkg::*;

    localparam int COORD_BITS  = 32;
    localparam int ANGLE_BITS  = 16;
    localparam int SINE_STAGES = 16;
    localparam int LATENCY     = SINE_STAGES + 4;
    localparam int RANDOM_BEATS = 1130;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   errors, pending, results;
    int   sent = 0;
    bit   stall_long = 1'b0;

    ax3r_in_if  #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) in_ch ();
    ax3r_out_if #(.COORD_BITS(COORD_BITS)) out_ch ();

    axis_rotate_3d_vector_unit #(
        .COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .SINE_STAGES(SINE_STAGES)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch)
    );

    axis_rotate_3d_vector_unit_checker #(
        .COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS), .SINE_STAGES(SINE_STAGES)
    ) scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Drive one beat at the falling edge after a random gap, and hold it
    // until the block takes it. Valid stays high across back-to-back beats.
    task automatic send_vector(input logic [1:0] axis, input logic [15:0] ang,
                               input logic [31:0] xv, input logic [31:0] yv,
                               input logic [31:0] zv, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= axis;
        in_ch.angle  <= ang;
        in_ch.x_in   <= xv;
        in_ch.y_in   <= yv;
        in_ch.z_in   <= zv;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    // Coordinates favor small values so rounding shows, with full-scale
    // and extreme ones mixed in to exercise saturation.
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255) - 128;
            3, 4: return $signed($urandom) >>> $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    // Receiver: a random stall per beat, except during the long hold-off,
    // and runs of steady ready so back-to-back flow is seen too.
    initial begin
        int wait_cycles;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_long) begin
                out_ch.ready <= 1'b0;
            end else if (out_ch.ready && !out_ch.valid) begin
                out_ch.ready <= 1'b1;
            end else begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
                if (wait_cycles > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (wait_cycles - 1) @(negedge i_clk);
                    @(negedge i_clk);
                end
                if (!stall_long) out_ch.ready <= 1'b1;
            end
        end
    end

    // Long hold-off in its own process, counted in cycles, while the
    // sender keeps pushing so the queue fills and input ready drops.
    initial begin
        wait (sent == 300);
        stall_long = 1'b1;
        repeat (200) @(negedge i_clk);
        stall_long = 1'b0;
    end

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.action = AXIS_X;
        in_ch.angle  = '0;
        in_ch.x_in   = '0;
        in_ch.y_in   = '0;
        in_ch.z_in   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: every axis plus the pass-through code, the quadrant
        // boundaries of the angle, and extreme coordinates.
        send_vector(AXIS_X, 16'h0000, 32'h00010000, 32'h00010000, 32'h00010000, 0);
        send_vector(AXIS_Y, 16'h4000, 32'h00010000, 32'h00020000, 32'hfffe0000, 0);
        send_vector(AXIS_Z, 16'h8000, 32'h00030000, 32'hffff0000, 32'h00050000, 0);
        send_vector(AXIS_NONE, 16'h1234, 32'h7fffffff, 32'h80000000, 32'h00000001, 0);
        send_vector(AXIS_X, 16'hc000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
        send_vector(AXIS_Y, 16'h2000, 32'h7fffffff, 32'h00000000, 32'h7fffffff, 0);
        send_vector(AXIS_Z, 16'h2000, 32'h80000000, 32'h80000000, 32'h0, 0);
        send_vector(AXIS_Z, 16'hffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1);
        send_vector(AXIS_X, 16'h0001, 32'h0, 32'h80000000, 32'h80000000, 1);
        send_vector(AXIS_Y, 16'h3fff, 32'h80000000, 32'h1, 32'h80000000, 1);
        send_vector(AXIS_NONE, 16'hffff, 32'hffffffff, 32'h0, 32'h80000000, 0);
        send_vector(AXIS_X, 16'h6000, 32'h1, 32'hffffffff, 32'h1, 0);
        send_vector(AXIS_Y, 16'he000, 32'h0, 32'h0, 32'h0, 0);
        send_vector(AXIS_Z, 16'ha000, 32'h00008000, 32'hffff8000, 32'h0, 0);

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            logic [1:0] axis;
            axis = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
            send_vector(axis, 16'($urandom), pick_coord(), pick_coord(), pick_coord(),
                        $urandom_range(0, 3) == 0);
        end
        in_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d input beats and %0d results over all axes,", sent, results);
        $display("full-range angles, saturating vectors and a long output stall.");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/ax3r_pkg.sv
hdl/ax3r_in_if.sv
hdl/ax3r_out_if.sv
hdl/ax3r_front.sv
hdl/ax3r_queue.sv
hdl/ax3r_back.sv
hdl/axis_rotate_3d_vector_unit.sv
tb/axis_rotate_3d_vector_unit_checker.sv
tb/axis_rotate_3d_vector_unit_test.sv
